/* hw/rtl/prfq_pkg.sv */
// Package for the paced report frame queue: sizes, codes, slot layout and
// the byte-mask helper. No dependencies; prfq_if.sv and the top level use it.
package prfq_pkg;

  // Queue sizing.
  localparam int SLOT_COUNT      = 48;
  localparam int MAX_FRAME_BYTES = 8;
  localparam int IDX_W           = $clog2(SLOT_COUNT);
  localparam int CNT_W           = $clog2(SLOT_COUNT + 1);

  // Field widths of the two channels.
  localparam int OPCODE_W = 2;
  localparam int LEN_W    = 4;
  localparam int BYTES_W  = 64;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 6;
  localparam int CTR_W    = 32;
  localparam int IVL_W    = 8;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(8);

  // Opcodes of an input beat.
  localparam logic [OPCODE_W-1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPLETE = 2'd2;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SENT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd5;

  // One queue slot as held in the RAM.
  typedef struct packed {
    logic               target;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] bytes;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Keeps the bytes below len and clears the rest.
  function automatic logic [BYTES_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [BYTES_W-1:0] m;
    m = '0;
    for (int i = 0; i < BYTES_W / 8; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/prfq_if.sv */
// Channel interfaces of the paced report frame queue: the command channel
// and the result channel. Depends on prfq_pkg.

interface prfq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [prfq_pkg::OPCODE_W-1:0]        opcode;
  logic                                 target;
  logic [prfq_pkg::LEN_W-1:0]           frame_len;
  logic [prfq_pkg::BYTES_W-1:0]         frame_bytes;
  logic [prfq_pkg::TIME_W-1:0]          now_ms;

  modport source (output valid, opcode, target, frame_len, frame_bytes, now_ms,
                  input ready);
  modport sink   (input valid, opcode, target, frame_len, frame_bytes, now_ms,
                  output ready);
endinterface

interface prfq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [prfq_pkg::STATUS_W-1:0]        status;
  logic                                 sent_target;
  logic [prfq_pkg::LEN_W-1:0]           sent_len;
  logic [prfq_pkg::BYTES_W-1:0]         sent_bytes;
  logic [prfq_pkg::DEPTH_W-1:0]         fill_level;
  logic [prfq_pkg::CTR_W-1:0]           dropped_total;
  logic [prfq_pkg::CTR_W-1:0]           keyboard_sent_total;
  logic [prfq_pkg::CTR_W-1:0]           mouse_sent_total;

  modport source (output valid, status, sent_target, sent_len, sent_bytes,
                  fill_level, dropped_total, keyboard_sent_total,
                  mouse_sent_total,
                  input ready);
  modport sink   (input valid, status, sent_target, sent_len, sent_bytes,
                  fill_level, dropped_total, keyboard_sent_total,
                  mouse_sent_total,
                  output ready);
endinterface

/* hw/rtl/prfq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address collision). No dependencies.
module prfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/paced_report_frame_queue_unit.sv */
// Top level of the paced report frame queue: slot RAM, pointers, pacing,
// endpoint busy marks, counters and the result register.
// Depends on prfq_pkg, prfq_if.sv and prfq_ram.
//
//  channel  | direction | handshake     | contents
//  ---------+-----------+---------------+------------------------------------
//  in_ch    | sink      | valid/ready   | opcode, target, frame_len, bytes, now
//  out_ch   | source    | valid/ready   | status, sent frame, depth, counters
//  cfg_*    | input     | write enable  | send_interval_ms
//
// Each beat is accepted and its result is in the result register at the next
// edge, so one beat per cycle is sustained while out_ch
// takes results. The slot RAM is read at the next head address every cycle,
// so the head frame is ready when a tick arrives. in_ch is stalled only while
// a result waits and out_ch is not ready. Reset (rst_n low, synchronous)
// clears pointers, counters and busy marks; the slot RAM is not cleared.
module paced_report_frame_queue_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  prfq_in_if.sink                   in_ch,
  prfq_out_if.source                out_ch,
  input  logic                      cfg_wr_en,
  input  logic [prfq_pkg::IVL_W-1:0] cfg_wr_data
);

  import prfq_pkg::*;

  // Control and data state.
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [TIME_W-1:0]   next_send_r, next_send_nxt;
  logic                kb_busy_r, kb_busy_nxt;
  logic                ms_busy_r, ms_busy_nxt;
  logic [CTR_W-1:0]    drop_cnt_r, drop_cnt_nxt;
  logic [CTR_W-1:0]    kb_cnt_r, kb_cnt_nxt;
  logic [CTR_W-1:0]    ms_cnt_r, ms_cnt_nxt;
  logic [IVL_W-1:0]    interval_r;

  // Head-slot bypass for a write that lands on the slot being read.
  logic                byp_vld_r;
  slot_t               byp_data_r;

  // Result register.
  logic                out_vld_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                s_target_r, s_target_nxt;
  logic [LEN_W-1:0]    s_len_r, s_len_nxt;
  logic [BYTES_W-1:0]  s_bytes_r, s_bytes_nxt;

  logic                accept;
  logic                len_ok;
  logic                full;
  logic                wr_en;
  slot_t               wr_slot;
  logic [SLOT_W-1:0]   rd_data;
  slot_t               head_slot;
  logic [TIME_W-1:0]   diff;
  logic                head_busy;

  // Handshake: a new beat is taken whenever the result register is free or drains.
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign len_ok  = (in_ch.frame_len != '0) && (in_ch.frame_len <= LEN_W'(MAX_FRAME_BYTES));
  assign full    = (fill_r == CNT_W'(SLOT_COUNT));
  assign wr_en   = accept && (in_ch.opcode == OP_ENQUEUE) && len_ok && !full;

  assign wr_slot.target = in_ch.target;
  assign wr_slot.len    = in_ch.frame_len;
  assign wr_slot.bytes  = in_ch.frame_bytes & byte_mask(in_ch.frame_len);

  assign head_slot = byp_vld_r ? byp_data_r : slot_t'(rd_data);
  assign diff      = in_ch.now_ms - next_send_r;
  assign head_busy = head_slot.target ? ms_busy_r : kb_busy_r;

  // Slot store; the read address is the next value of the head pointer.
  prfq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_slot),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  // Per-beat work: queue, send or complete.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    next_send_nxt = next_send_r;
    kb_busy_nxt   = kb_busy_r;
    ms_busy_nxt   = ms_busy_r;
    drop_cnt_nxt  = drop_cnt_r;
    kb_cnt_nxt    = kb_cnt_r;
    ms_cnt_nxt    = ms_cnt_r;
    status_nxt    = ST_NONE;
    s_target_nxt  = 1'b0;
    s_len_nxt     = '0;
    s_bytes_nxt   = '0;
    if (accept) begin
      case (in_ch.opcode)
        OP_ENQUEUE: begin
          if (!len_ok) begin
            status_nxt = ST_BAD_LEN;
          end else if (full) begin
            drop_cnt_nxt = drop_cnt_r + 1'b1;
            status_nxt   = ST_DROPPED;
          end else begin
            tail_nxt   = (tail_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
            status_nxt = ST_QUEUED;
          end
        end
        OP_TICK: begin
          if ((fill_r != '0) && !diff[TIME_W-1] && !head_busy) begin
            if (head_slot.target) begin
              ms_busy_nxt = 1'b1;
              ms_cnt_nxt  = ms_cnt_r + 1'b1;
            end else begin
              kb_busy_nxt = 1'b1;
              kb_cnt_nxt  = kb_cnt_r + 1'b1;
            end
            s_target_nxt  = head_slot.target;
            s_len_nxt     = head_slot.len;
            s_bytes_nxt   = head_slot.bytes;
            head_nxt      = (head_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
            fill_nxt      = fill_r - 1'b1;
            next_send_nxt = in_ch.now_ms + TIME_W'(interval_r);
            status_nxt    = ST_SENT;
          end
        end
        OP_COMPLETE: begin
          if (in_ch.target) begin
            ms_busy_nxt = 1'b0;
          end else begin
            kb_busy_nxt = 1'b0;
          end
          status_nxt = ST_DONE;
        end
        default: begin
          status_nxt = ST_NONE;
        end
      endcase
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      next_send_r <= '0;
      kb_busy_r   <= 1'b0;
      ms_busy_r   <= 1'b0;
      drop_cnt_r  <= '0;
      kb_cnt_r    <= '0;
      ms_cnt_r    <= '0;
      interval_r  <= IVL_RESET;
      byp_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      next_send_r <= next_send_nxt;
      kb_busy_r   <= kb_busy_nxt;
      ms_busy_r   <= ms_busy_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      kb_cnt_r    <= kb_cnt_nxt;
      ms_cnt_r    <= ms_cnt_nxt;
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      byp_vld_r <= wr_en && (tail_r == head_nxt);
      if (accept) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: bypass slot and the result beat.
  always_ff @(posedge clk) begin
    byp_data_r <= wr_slot;
    if (accept) begin
      status_r   <= status_nxt;
      s_target_r <= s_target_nxt;
      s_len_r    <= s_len_nxt;
      s_bytes_r  <= s_bytes_nxt;
    end
  end

  // Result channel; the totals are only updated by an accepted beat.
  assign out_ch.valid               = out_vld_r;
  assign out_ch.status              = status_r;
  assign out_ch.sent_target         = s_target_r;
  assign out_ch.sent_len            = s_len_r;
  assign out_ch.sent_bytes          = s_bytes_r;
  assign out_ch.fill_level          = DEPTH_W'(fill_r);
  assign out_ch.dropped_total       = drop_cnt_r;
  assign out_ch.keyboard_sent_total = kb_cnt_r;
  assign out_ch.mouse_sent_total    = ms_cnt_r;

  // The fill count never passes the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(SLOT_COUNT))
    else $error("fill count beyond queue depth");

  // Empty or full ring: head and tail pointers meet.
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0 || fill_r == CNT_W'(SLOT_COUNT)) |-> (head_r == tail_r))
    else $error("head and tail disagree with fill count");

  // A sent frame always carries a legal length.
  a_sent_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r == ST_SENT) |->
      (s_len_r != '0 && s_len_r <= LEN_W'(MAX_FRAME_BYTES)))
    else $error("sent frame with illegal length");

endmodule
